// ----- design/bdlp_pkg.sv -----
// ---------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debounce / long-press core.
// ---------------------------------------------------------------------------
package bdlp_pkg;

  // hold bands, in millisecond ticks
  localparam logic [15:0] HOLD_5S     = 16'd5000;
  localparam logic [15:0] HOLD_10S    = 16'd10000;
  localparam logic [15:0] HOLD_30S    = 16'd30000;
  localparam logic [15:0] HOLD_35S    = 16'd35000;
  localparam logic [15:0] HOLD_MAX    = 16'hFFFF;

  // register reset values
  localparam logic [15:0] SENS_RESET  = 16'd50;
  localparam logic        MULTI_RESET = 1'b0;
  localparam logic        IDLE_RESET  = 1'b1;

  localparam int unsigned RES_W   = 9;
  localparam int unsigned TDATA_W = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SENSITIVITY = 2'd0,
    REG_MULTI_MODE  = 2'd1,
    REG_IDLE_LEVEL  = 2'd2
  } cfg_reg_e;

  // configuration write
  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  // one result; declared top down so switch_state lands in bit 0
  typedef struct packed {
    logic release_30s;
    logic release_10s;
    logic release_5s;
    logic over_35s;
    logic announce_30s;
    logic announce_10s;
    logic announce_5s;
    logic press_event;
    logic switch_state;
  } result_t;

endpackage

// ----- design/bdlp_tracker.sv -----
// ---------------------------------------------------------------------------
// bdlp_tracker
// Configuration registers, hold state and the per-tick result logic.
// ---------------------------------------------------------------------------
module bdlp_tracker import bdlp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  logic    tick,        // input transfer this cycle
  input  logic    level,
  output result_t res,
  output logic    multi_mode
);

  logic [15:0] sensitivity_ms;
  logic        idle_level;
  logic        toggled_state;
  logic        holding;
  logic [15:0] hold_ticks;
  logic        press_taken;
  logic [2:0]  announced_flags;

  logic        held;
  logic [15:0] ticks_inc;
  logic [15:0] elapsed;
  logic        qual;
  logic        press;
  logic        mm;
  logic        a5;
  logic        a10;
  logic        a30;
  logic        rel;

  // elapsed time of this tick
  assign held      = (level != idle_level);
  assign ticks_inc = (hold_ticks == HOLD_MAX) ? HOLD_MAX : hold_ticks + 16'd1;
  assign elapsed   = holding ? ticks_inc : 16'd0;

  // press and announce decisions
  assign qual  = held && (elapsed >= sensitivity_ms);
  assign press = qual && !press_taken;
  assign mm    = qual && multi_mode;
  assign a5    = mm && (elapsed >= HOLD_5S)  && !announced_flags[0];
  assign a10   = mm && (elapsed >= HOLD_10S) && !announced_flags[1];
  assign a30   = mm && (elapsed >= HOLD_30S) && !announced_flags[2];
  assign rel   = !held && holding && multi_mode;

  // result fields; release class uses ticks_inc as the release duration
  always_comb begin
    res.switch_state = toggled_state ^ press;
    res.press_event  = press;
    res.announce_5s  = a5;
    res.announce_10s = a10;
    res.announce_30s = a30;
    res.over_35s     = mm && (elapsed >= HOLD_35S);
    res.release_5s   = rel && (ticks_inc >= HOLD_5S)  && (ticks_inc < HOLD_10S);
    res.release_10s  = rel && (ticks_inc >= HOLD_10S) && (ticks_inc < HOLD_30S);
    res.release_30s  = rel && (ticks_inc >= HOLD_30S) && (ticks_inc < HOLD_35S);
  end

  // config registers and hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity_ms  <= SENS_RESET;
      multi_mode      <= MULTI_RESET;
      idle_level      <= IDLE_RESET;
      toggled_state   <= IDLE_RESET;
      holding         <= 1'b0;
      hold_ticks      <= 16'd0;
      press_taken     <= 1'b0;
      announced_flags <= 3'd0;
    end else begin
      if (tick) begin
        if (held) begin
          holding         <= 1'b1;
          hold_ticks      <= elapsed;
          press_taken     <= press_taken | press;
          announced_flags <= announced_flags | {a30, a10, a5};
          toggled_state   <= toggled_state ^ press;
        end else if (holding) begin
          holding         <= 1'b0;
          hold_ticks      <= 16'd0;
          press_taken     <= 1'b0;
          announced_flags <= 3'd0;
        end
      end
      if (cfg.valid) begin
        unique case (cfg_reg_e'(cfg.index))
          REG_SENSITIVITY: sensitivity_ms <= cfg.data;
          REG_MULTI_MODE:  multi_mode     <= cfg.data[0];
          REG_IDLE_LEVEL: begin
            idle_level    <= cfg.data[0];
            toggled_state <= cfg.data[0];
          end
          default: ;  // unknown index, ignored
        endcase
      end
    end
  end

endmodule

// ----- design/bdlp_skid.sv -----
// ---------------------------------------------------------------------------
// bdlp_skid
// Two-entry output buffer; ready toward the source is a register.
// ---------------------------------------------------------------------------
module bdlp_skid import bdlp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data,
  output logic    skd_valid
);

  result_t skd_data;
  logic    in_fire;

  assign in_ready = !skd_valid;
  assign in_fire  = in_valid && in_ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skd_valid <= 1'b0;
    end else if (skd_valid) begin
      if (out_ready) begin
        skd_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skd_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skd_valid) begin
      if (out_ready) begin
        out_data <= skd_data;
      end
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skd_data <= in_data;
      end else begin
        out_data <= in_data;
      end
    end
  end

endmodule

// ----- design/button_debounce_long_press_core.sv -----
// A result is registered in the output register, or in the skid entry while
// m_tready is low. Throughput: one tick per cycle while s_tready is high.
// The skid entry takes one result in an output stall; s_tready then drops.
// Reset (rst, synchronous): sensitivity 50, multi mode off, idle level 1,
// switch state 1, no hold in progress, output buffer empty.
// ---------------------------------------------------------------------------
// button_debounce_long_press_core
// Debounces a sampled button pin, toggles a switch on a qualified press and
// reports long-press announce and release classes.
// ---------------------------------------------------------------------------
module button_debounce_long_press_core import bdlp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [0] level
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [0] switch_state [1] press_event [2] announce_5s [3] announce_10s
  // [4] announce_30s [5] over_35s [6] release_5s [7] release_10s
  // [8] release_30s, rest zero
  output logic [TDATA_W-1:0]   m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_wr_t cfg;
  result_t res;
  result_t out_res;
  logic    tick;
  logic    multi_mode;
  logic    skd_valid;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;
  assign tick      = s_tvalid && s_tready;

  // hold tracking and result logic
  bdlp_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick       (tick),
    .level      (s_tdata[0]),
    .res        (res),
    .multi_mode (multi_mode)
  );

  // output buffer
  bdlp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res),
    .skd_valid (skd_valid)
  );

  assign m_tdata = {{(TDATA_W - RES_W){1'b0}}, out_res};

`ifndef ASSERT_OFF
  // the skid entry is only filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skd_valid |-> m_tvalid)
    else $error("skid entry valid while output register empty");

  // announces and release classes only in multi mode
  a_multi_only: assert property (@(posedge clk) disable iff (rst)
    (tick && !multi_mode) |-> !(res.announce_5s || res.announce_10s ||
      res.announce_30s || res.over_35s || res.release_5s ||
      res.release_10s || res.release_30s))
    else $error("long-press output outside multi mode");

  // a release tick gives at most one class and no held-tick outputs
  a_release_class: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($onehot0({out_res.release_5s, out_res.release_10s,
      out_res.release_30s}) &&
      !((out_res.release_5s || out_res.release_10s || out_res.release_30s) &&
        (out_res.press_event || out_res.over_35s))))
    else $error("conflicting release class outputs");
`endif

endmodule
